// ===== design/hrlp_pkg.sv =====
// Package: shared types and constants of the HID report length parser.
`default_nettype none
package hrlp_pkg;

  localparam int NEST_LIMIT = 32;
  localparam int ID_SLOTS   = 32;
  localparam int BIT_LIMIT  = 32768;

  localparam int STK_AW = $clog2(NEST_LIMIT);
  localparam int BKT_AW = $clog2(ID_SLOTS);
  localparam int DEPTH_W = $clog2(NEST_LIMIT + 1) + 1;
  localparam int CNT_W   = $clog2(ID_SLOTS + 1);
  localparam int BITS_W  = 17;

  localparam logic [7:0] LONG_PREFIX = 8'hFE;

  localparam logic [1:0] CLASS_MAIN   = 2'd0;
  localparam logic [1:0] CLASS_GLOBAL = 2'd1;

  localparam logic [3:0] TAG_REPORT_SIZE  = 4'h7;
  localparam logic [3:0] TAG_REPORT_ID    = 4'h8;
  localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;
  localparam logic [3:0] TAG_PUSH         = 4'hA;
  localparam logic [3:0] TAG_POP          = 4'hB;
  localparam logic [3:0] TAG_OUTPUT       = 4'h9;
  localparam logic [3:0] TAG_COLLECTION   = 4'hA;
  localparam logic [3:0] TAG_FEATURE      = 4'hB;
  localparam logic [3:0] TAG_END_COLL     = 4'hC;

  typedef enum logic [2:0] {
    PH_PREFIX, PH_SHORT, PH_LSIZE, PH_LTAG, PH_LDATA
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTE,
    ST_POP_RD,
    ST_POP_WB,
    ST_MUL,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_ADD_WB,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_LEN,
    ST_RESULT
  } state_t;

  // One bucket entry: report ID, output bits, feature bits.
  typedef struct packed {
    logic [31:0]       id;
    logic [BITS_W-1:0] out_bits;
    logic [BITS_W-1:0] feat_bits;
  } bucket_t;

  // One saved global frame.
  typedef struct packed {
    logic [31:0] size;
    logic [31:0] count;
    logic [31:0] id;
  } globals_t;

endpackage
`default_nettype wire

// ===== design/hrlp_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module hrlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed entry when we is high; read one entry a cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== design/hid_report_length_parser.sv =====
// Top level: HID report descriptor length parser.
//
// Usage: descriptor bytes arrive on the in_ channel (in_valid / in_stall),
// one transaction per byte, with in_has_byte qualifying in_data_byte and
// in_last closing the descriptor. A transaction with in_last high yields
// exactly one result transaction on the out_ channel: out_ok and the
// largest output and feature report byte lengths (ID byte included).
// cfg_we / cfg_wdata write max_report_bytes (reset 193); the user must do so
// only while idle, as the block itself does not enforce it. A transaction
// is taken only while the block is idle. A Pop reads the stack memory and
// restores the globals; an Output/Feature item over the bit limit skips the
// one-port bucket search, which else runs a read and a compare per entry
// over the report IDs in use. The closing transaction scans all buckets first.
// The result sits in an output register; in_stall stays high while a
// result is held, and while out_stall is high the result holds steady.
// Reset (rst_n low, synchronous) clears all control state; the stack and
// bucket memories need no clearing since entries are read only after
// being written (a fill count bounds the bucket search).
`default_nettype none
module hid_report_length_parser
  import hrlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_has_byte,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic [12:0]      out_output_length,
  output logic [12:0]      out_feature_length
);

  state_t state_r, state_nxt;

  logic [12:0]        max_bytes_r;
  logic               has_r, last_r;
  logic [7:0]         byte_r;
  phase_t             phase_r;
  logic [7:0]         left_r;
  logic [2:0]         item_bytes_r;
  logic [31:0]        value_r;
  logic [3:0]         kind_r;
  logic [1:0]         class_r;
  logic [31:0]        size_r, count_r, id_r;
  logic [DEPTH_W-1:0] push_r, nest_r;
  logic [CNT_W-1:0]   bcnt_r;
  logic [CNT_W-1:0]   k_r;
  logic               failed_r;
  logic               is_out_r;
  logic [63:0]        prod_r;
  logic [BITS_W-1:0]  add_r;
  bucket_t            bkt_r;
  logic [BITS_W-1:0]  mo_r, mf_r;
  logic [13:0]        ol_r, fl_r;

  // Memory ports.
  logic              stk_we;
  logic [STK_AW-1:0] stk_addr;
  globals_t          stk_wdata, stk_rdata;
  logic              bkt_we;
  logic [BKT_AW-1:0] bkt_addr;
  bucket_t           bkt_wdata, bkt_rdata;

  hrlp_ram #(.WIDTH($bits(globals_t)), .DEPTH(NEST_LIMIT)) u_stack (
    .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata)
  );

  hrlp_ram #(.WIDTH($bits(bucket_t)), .DEPTH(ID_SLOTS)) u_buckets (
    .clk(clk), .we(bkt_we), .addr(bkt_addr), .wdata(bkt_wdata), .rdata(bkt_rdata)
  );

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESULT);

  // Decode of the byte held in the byte stage.
  logic       run_now;
  logic [31:0] val_now;
  logic [3:0] kind_now;
  logic [1:0] class_now;
  logic [2:0] nbytes;
  always_comb begin
    run_now   = 1'b0;
    val_now   = value_r;
    kind_now  = kind_r;
    class_now = class_r;
    nbytes    = 3'd0;
    unique case (byte_r[1:0])
      2'd0: nbytes = 3'd0;
      2'd1: nbytes = 3'd1;
      2'd2: nbytes = 3'd2;
      2'd3: nbytes = 3'd4;
    endcase
    if (has_r && !failed_r) begin
      if (phase_r == PH_PREFIX && byte_r != LONG_PREFIX) begin
        kind_now  = byte_r[7:4];
        class_now = byte_r[3:2];
        val_now   = 32'd0;
        run_now   = (nbytes == 3'd0);
      end else if (phase_r == PH_SHORT) begin
        unique case (2'(item_bytes_r - left_r[2:0]))
          2'd0: val_now = value_r | {24'd0, byte_r};
          2'd1: val_now = value_r | {16'd0, byte_r, 8'd0};
          2'd2: val_now = value_r | {8'd0, byte_r, 16'd0};
          2'd3: val_now = value_r | {byte_r, 24'd0};
        endcase
        run_now = (left_r == 8'd1);
      end
    end
  end

  logic is_pop, is_addbits;
  assign is_pop = run_now && class_now == CLASS_GLOBAL && kind_now == TAG_POP
                  && push_r != '0;
  assign is_addbits = run_now && class_now == CLASS_MAIN
                      && (kind_now == TAG_OUTPUT || kind_now == TAG_FEATURE);

  logic match_now;
  assign match_now = (bkt_rdata.id == id_r);

  logic [BITS_W:0] sum_out, sum_feat;
  assign sum_out  = {1'b0, bkt_r.out_bits}  + {1'b0, add_r};
  assign sum_feat = {1'b0, bkt_r.feat_bits} + {1'b0, add_r};

  logic fail_end;
  assign fail_end = failed_r || phase_r != PH_PREFIX || nest_r != '0 || push_r != '0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_BYTE;
      ST_BYTE: begin
        if (is_pop)          state_nxt = ST_POP_RD;
        else if (is_addbits) state_nxt = ST_MUL;
        else if (last_r)     state_nxt = ST_SCAN_RD;
        else                 state_nxt = ST_IDLE;
      end
      ST_POP_RD:   state_nxt = ST_POP_WB;
      ST_POP_WB:   state_nxt = last_r ? ST_SCAN_RD : ST_IDLE;
      ST_MUL: begin
        if (prod_r > 64'(BIT_LIMIT)) state_nxt = last_r ? ST_SCAN_RD : ST_IDLE;
        else                         state_nxt = ST_SRCH_RD;
      end
      ST_SRCH_RD: begin
        if (k_r == bcnt_r) state_nxt = ST_ADD_WB;
        else               state_nxt = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: state_nxt = match_now ? ST_ADD_WB : ST_SRCH_RD;
      ST_ADD_WB:   state_nxt = last_r ? ST_SCAN_RD : ST_IDLE;
      ST_SCAN_RD:  state_nxt = (k_r == bcnt_r) ? ST_LEN : ST_SCAN_CHK;
      ST_SCAN_CHK: state_nxt = ST_SCAN_RD;
      ST_LEN:      state_nxt = ST_RESULT;
      ST_RESULT:   if (out_acc) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Memory control outputs.
  always_comb begin
    stk_we    = 1'b0;
    stk_addr  = push_r[STK_AW-1:0];
    stk_wdata = '{size: size_r, count: count_r, id: id_r};
    bkt_we    = 1'b0;
    bkt_addr  = k_r[BKT_AW-1:0];
    bkt_wdata = bkt_r;
    unique case (state_r)
      ST_BYTE: begin
        if (run_now && class_now == CLASS_GLOBAL && kind_now == TAG_PUSH
            && push_r < DEPTH_W'(NEST_LIMIT)) begin
          stk_we = 1'b1;
        end
        if (is_pop) stk_addr = STK_AW'(push_r - 1'b1);
      end
      ST_ADD_WB: begin
        bkt_we = (k_r < bcnt_r) || (bcnt_r < CNT_W'(ID_SLOTS));
        if (is_out_r) bkt_wdata.out_bits  = sum_out[BITS_W-1:0];
        else          bkt_wdata.feat_bits = sum_feat[BITS_W-1:0];
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) max_bytes_r <= 13'd193;
    else if (cfg_we) max_bytes_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_PREFIX;
      left_r   <= '0;
      value_r  <= '0;
      kind_r   <= '0;
      class_r  <= '0;
      item_bytes_r <= '0;
      size_r   <= '0;
      count_r  <= '0;
      id_r     <= '0;
      push_r   <= '0;
      nest_r   <= '0;
      bcnt_r   <= '0;
      k_r      <= '0;
      failed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: k_r <= '0;
        ST_BYTE: begin
          value_r <= val_now;
          kind_r  <= kind_now;
          class_r <= class_now;
          if (has_r && !failed_r) begin
            unique case (phase_r)
              PH_PREFIX: begin
                if (byte_r == LONG_PREFIX) begin
                  phase_r <= PH_LSIZE;
                end else begin
                  item_bytes_r <= nbytes;
                  left_r       <= {5'd0, nbytes};
                  if (nbytes != 3'd0) phase_r <= PH_SHORT;
                end
              end
              PH_SHORT: begin
                left_r <= left_r - 1'b1;
                if (left_r == 8'd1) phase_r <= PH_PREFIX;
              end
              PH_LSIZE: begin
                left_r  <= byte_r;
                phase_r <= PH_LTAG;
              end
              PH_LTAG: phase_r <= (left_r == 8'd0) ? PH_PREFIX : PH_LDATA;
              PH_LDATA: begin
                if (left_r <= 8'd1) phase_r <= PH_PREFIX;
                if (left_r != 8'd0) left_r <= left_r - 1'b1;
              end
              default: phase_r <= PH_PREFIX;
            endcase
          end
          // Execute the item that completed with this byte.
          if (run_now && class_now == CLASS_GLOBAL) begin
            unique case (kind_now)
              TAG_REPORT_SIZE:  size_r  <= val_now;
              TAG_REPORT_ID:    id_r    <= val_now;
              TAG_REPORT_COUNT: count_r <= val_now;
              TAG_PUSH: begin
                if (push_r >= DEPTH_W'(NEST_LIMIT)) failed_r <= 1'b1;
                else push_r <= push_r + 1'b1;
              end
              TAG_POP: begin
                if (push_r == '0) failed_r <= 1'b1;
                else push_r <= push_r - 1'b1;
              end
              default: ;
            endcase
          end else if (run_now && class_now == CLASS_MAIN) begin
            unique case (kind_now)
              TAG_COLLECTION: begin
                nest_r <= nest_r + 1'b1;
                if (nest_r >= DEPTH_W'(NEST_LIMIT)) failed_r <= 1'b1;
              end
              TAG_END_COLL: begin
                if (nest_r == '0) failed_r <= 1'b1;
                else nest_r <= nest_r - 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_POP_WB: begin
          size_r  <= stk_rdata.size;
          count_r <= stk_rdata.count;
          id_r    <= stk_rdata.id;
        end
        ST_MUL: begin
          if (prod_r > 64'(BIT_LIMIT)) failed_r <= 1'b1;
        end
        ST_SRCH_CHK: if (!match_now) k_r <= k_r + 1'b1;
        ST_ADD_WB: begin
          k_r <= '0;
          if (k_r == bcnt_r && bcnt_r < CNT_W'(ID_SLOTS)) bcnt_r <= bcnt_r + 1'b1;
          // Fail on a new ID with all slots in use, or on a bucket over the limit.
          if ((k_r == bcnt_r && bcnt_r >= CNT_W'(ID_SLOTS))
              || (is_out_r ? (sum_out > (BITS_W+1)'(BIT_LIMIT))
                           : (sum_feat > (BITS_W+1)'(BIT_LIMIT)))) begin
            failed_r <= 1'b1;
          end
        end
        ST_SCAN_CHK: k_r <= k_r + 1'b1;
        ST_RESULT: begin
          if (out_acc) begin
            phase_r  <= PH_PREFIX;
            left_r   <= '0;
            value_r  <= '0;
            kind_r   <= '0;
            class_r  <= '0;
            item_bytes_r <= '0;
            size_r   <= '0;
            count_r  <= '0;
            id_r     <= '0;
            push_r   <= '0;
            nest_r   <= '0;
            bcnt_r   <= '0;
            failed_r <= 1'b0;
          end
        end
        default: ;
      endcase
      if (state_r == ST_MUL && prod_r > 64'(BIT_LIMIT)) k_r <= '0;
    end
  end

  // Payload registers: input stage, multiply, bucket and scan values.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      has_r  <= in_has_byte;
      byte_r <= in_data_byte;
      last_r <= in_last;
    end
    if (state_r == ST_BYTE) begin
      prod_r   <= size_r * count_r;
      is_out_r <= (kind_now == TAG_OUTPUT);
    end
    if (state_r == ST_MUL) add_r <= prod_r[BITS_W-1:0];
    // Seed a new bucket; replaced by the stored entry on a match.
    if (state_r == ST_MUL || (state_r == ST_SRCH_CHK && !match_now)) begin
      bkt_r <= '{id: id_r, out_bits: '0, feat_bits: '0};
    end
    if (state_r == ST_SRCH_CHK && match_now) bkt_r <= bkt_rdata;
    if (state_r == ST_IDLE) begin
      mo_r <= '0;
      mf_r <= '0;
    end
    if (state_r == ST_SCAN_CHK) begin
      if (bkt_rdata.out_bits > mo_r)  mo_r <= bkt_rdata.out_bits;
      if (bkt_rdata.feat_bits > mf_r) mf_r <= bkt_rdata.feat_bits;
    end
    if (state_r == ST_LEN) begin
      ol_r <= (mo_r == '0) ? 14'd0 : 14'((mo_r + BITS_W'(7)) >> 3) + 14'd1;
      fl_r <= (mf_r == '0) ? 14'd0 : 14'((mf_r + BITS_W'(7)) >> 3) + 14'd1;
      out_ok <= !fail_end
                && !((mo_r != '0)
                     && (14'((mo_r + BITS_W'(7)) >> 3) + 14'd1) > {1'b0, max_bytes_r})
                && !((mf_r != '0)
                     && (14'((mf_r + BITS_W'(7)) >> 3) + 14'd1) > {1'b0, max_bytes_r});
    end
  end

  assign out_output_length  = out_ok ? ol_r[12:0] : 13'd0;
  assign out_feature_length = out_ok ? fl_r[12:0] : 13'd0;

  // Checks.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    push_r <= DEPTH_W'(NEST_LIMIT))
    else $error("push depth beyond stack size");
  a_bcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= CNT_W'(ID_SLOTS))
    else $error("bucket count beyond slots");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok))
    else $error("result dropped under stall");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken with result pending");

endmodule
`default_nettype wire

// ===== bench/hid_report_length_parser_test.sv =====
// Testbench: HID report length parser, checked against its own descriptor parser model.
`timescale 1ns / 100ps
module hid_report_length_parser_test;
  import hrlp_pkg::*;

  localparam logic [1:0] CLASS_LOCAL = 2'd2;
  localparam logic [1:0] SZ_NONE = 2'd0;
  localparam logic [1:0] SZ_ONE  = 2'd1;
  localparam logic [1:0] SZ_TWO  = 2'd2;
  localparam logic [1:0] SZ_FOUR = 2'd3;
  // settle time after the final expected result: bucket scan plus margin
  localparam int SETTLE_CYCLES = 2 * ID_SLOTS + 40;
  localparam int RESET_MAX = 193;

  typedef struct {
    logic        ok;
    logic [12:0] out_len;
    logic [12:0] feat_len;
  } lengths_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_has_byte;
  logic [7:0]  in_data_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic        out_ok;
  logic [12:0] out_output_length;
  logic [12:0] out_feature_length;

  hid_report_length_parser dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_has_byte(in_has_byte), .in_data_byte(in_data_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ok(out_ok), .out_output_length(out_output_length),
    .out_feature_length(out_feature_length)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // descriptor parser model state
  int unsigned max_len;
  phase_t      ph;
  int unsigned left, val, kind, cls, nbytes;
  int unsigned rsize, rcount, rid;
  int unsigned stk_size [NEST_LIMIT];
  int unsigned stk_count [NEST_LIMIT];
  int unsigned stk_id [NEST_LIMIT];
  int unsigned push_d, nest_d, nb;
  int unsigned bkt_id [ID_SLOTS];
  int unsigned bkt_out [ID_SLOTS];
  int unsigned bkt_feat [ID_SLOTS];
  bit          bad;

  lengths_t    lengths_q[$];
  logic [7:0]  desc_q[$];
  int          mismatches;
  int          bytes_sent;
  int          results_seen;
  int          hold_cycles;
  bit          eager;

  task automatic parser_clear();
    ph = PH_PREFIX; left = 0; val = 0; kind = 0; cls = 0; nbytes = 0;
    rsize = 0; rcount = 0; rid = 0; push_d = 0; nest_d = 0; nb = 0; bad = 1'b0;
  endtask

  task automatic parser_account(bit is_out);
    longint unsigned prod;
    int slot;
    int unsigned total;
    prod = longint'(rsize) * longint'(rcount);
    slot = -1;
    if (prod > BIT_LIMIT) begin
      bad = 1'b1;
      return;
    end
    for (int k = 0; k < nb; k++) begin
      if (slot < 0 && bkt_id[k] == rid) slot = k;
    end
    // open a new bucket for an unseen ID
    if (slot < 0) begin
      if (nb >= ID_SLOTS) begin
        bad = 1'b1;
        return;
      end
      slot = nb;
      nb++;
      bkt_id[slot] = rid; bkt_out[slot] = 0; bkt_feat[slot] = 0;
    end
    if (is_out) begin
      bkt_out[slot] += int'(prod);
      total = bkt_out[slot];
    end else begin
      bkt_feat[slot] += int'(prod);
      total = bkt_feat[slot];
    end
    if (total > BIT_LIMIT) bad = 1'b1;
  endtask

  task automatic parser_exec();
    if (cls == CLASS_GLOBAL) begin
      case (4'(kind))
        TAG_REPORT_SIZE:  rsize = val;
        TAG_REPORT_ID:    rid = val;
        TAG_REPORT_COUNT: rcount = val;
        TAG_PUSH: begin
          if (push_d >= NEST_LIMIT) bad = 1'b1;
          else begin
            stk_size[push_d] = rsize; stk_count[push_d] = rcount; stk_id[push_d] = rid;
            push_d++;
          end
        end
        TAG_POP: begin
          if (push_d == 0) bad = 1'b1;
          else begin
            push_d--;
            rsize = stk_size[push_d]; rcount = stk_count[push_d]; rid = stk_id[push_d];
          end
        end
        default: ;
      endcase
    end else if (cls == CLASS_MAIN) begin
      case (4'(kind))
        TAG_COLLECTION: begin
          nest_d++;
          if (nest_d > NEST_LIMIT) bad = 1'b1;
        end
        TAG_END_COLL: begin
          if (nest_d == 0) bad = 1'b1;
          else nest_d--;
        end
        TAG_OUTPUT:  parser_account(1'b1);
        TAG_FEATURE: parser_account(1'b0);
        default: ;
      endcase
    end
  endtask

  task automatic parser_take(logic [7:0] b);
    int unsigned idx;
    case (ph)
      PH_PREFIX: begin
        if (b == LONG_PREFIX) ph = PH_LSIZE;
        else begin
          cls = b[3:2];
          kind = b[7:4];
          nbytes = (b[1:0] == SZ_FOUR) ? 4 : b[1:0];
          left = nbytes;
          val = 0;
          if (left == 0) parser_exec();
          else ph = PH_SHORT;
        end
      end
      PH_SHORT: begin
        idx = (nbytes - left) & 3;
        val |= 32'(b) << (8 * idx);
        left--;
        if (left == 0) begin
          ph = PH_PREFIX;
          parser_exec();
        end
      end
      PH_LSIZE: begin
        left = b;
        ph = PH_LTAG;
      end
      PH_LTAG: ph = (left == 0) ? PH_PREFIX : PH_LDATA;
      default: begin
        if (left > 0) left--;
        if (left == 0) ph = PH_PREFIX;
      end
    endcase
  endtask

  function automatic int unsigned bytes_for(int unsigned bits);
    return (bits != 0) ? (bits + 7) / 8 + 1 : 0;
  endfunction

  // advance the model by one accepted transaction
  task automatic parser_accept(logic has, logic [7:0] b, logic lst);
    lengths_t r;
    int unsigned mo, mf, ol, fl;
    bit good;
    mo = 0; mf = 0;
    if (has && !bad) parser_take(b);
    if (lst) begin
      good = !bad && ph == PH_PREFIX && nest_d == 0 && push_d == 0;
      for (int k = 0; k < nb; k++) begin
        if (bkt_out[k] > mo) mo = bkt_out[k];
        if (bkt_feat[k] > mf) mf = bkt_feat[k];
      end
      ol = bytes_for(mo);
      fl = bytes_for(mf);
      if (ol > max_len || fl > max_len) good = 1'b0;
      if (!good) begin
        ol = 0; fl = 0;
      end
      r.ok = good; r.out_len = 13'(ol); r.feat_len = 13'(fl);
      lengths_q.push_back(r);
      parser_clear();
    end
  endtask

  task automatic note_mismatch(string what, int exp_v, int act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    lengths_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (lengths_q.size() == 0) note_mismatch("unexpected result", 0, 1);
      else begin
        e = lengths_q.pop_front();
        if (out_ok !== e.ok) note_mismatch("ok", e.ok, out_ok);
        if (out_output_length !== e.out_len)
          note_mismatch("output_length", e.out_len, out_output_length);
        if (out_feature_length !== e.feat_len)
          note_mismatch("feature_length", e.feat_len, out_feature_length);
      end
    end
  end

  // receiver: stall a random number of cycles before each result
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = eager ? 0 : $urandom_range(0, 15);
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end
      if (gap > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // send one transaction and hold it until accepted
  task automatic send_item(logic has, logic [7:0] b, logic lst);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_has_byte <= has;
    in_data_byte <= b;
    in_last <= lst;
    do @(posedge clk); while (in_stall);
    parser_accept(has, b, lst);
    if (has) bytes_sent++;
  endtask

  // send the built descriptor, either closing on its final byte or with an empty end
  task automatic send_desc(bit empty_end, bit idles);
    int n;
    n = desc_q.size();
    for (int i = 0; i < n; i++) begin
      if (idles && $urandom_range(0, 7) == 0) send_item(1'b0, 8'($urandom), 1'b0);
      send_item(1'b1, desc_q[i], (i == n - 1) && !empty_end);
    end
    if (empty_end || n == 0) send_item(1'b0, 8'($urandom), 1'b1);
    desc_q.delete();
  endtask

  task automatic put_short(logic [1:0] c, logic [3:0] tag, int unsigned v, logic [1:0] code);
    int unsigned n;
    n = (code == SZ_FOUR) ? 4 : code;
    desc_q.push_back({tag, c, code});
    for (int i = 0; i < n; i++) desc_q.push_back(8'(v >> (8 * i)));
  endtask

  task automatic put_long(int unsigned len);
    desc_q.push_back(LONG_PREFIX);
    desc_q.push_back(8'(len));
    desc_q.push_back(8'($urandom));
    repeat (len) desc_q.push_back(8'($urandom));
  endtask

  // drain, wait out any trailing work, then leave the block idle
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (lengths_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(int unsigned v);
    wait_idle();
    @(negedge clk) begin
      cfg_we <= 1'b1;
      cfg_wdata <= 13'(v);
    end
    @(negedge clk) cfg_we <= 1'b0;
    max_len = v;
  endtask

  task automatic test_directed();
    // empty descriptor, and an idle step before an empty end
    send_desc(1'b1, 1'b0);
    send_item(1'b0, 8'hFF, 1'b0);
    send_item(1'b0, 8'h00, 1'b1);
    // well formed mix: globals, push/pop, collection, local, long item
    put_short(CLASS_MAIN, TAG_COLLECTION, 1, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 8, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, 3, SZ_TWO);
    put_short(CLASS_GLOBAL, TAG_REPORT_ID, 1, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_PUSH, 0, SZ_NONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 16, SZ_FOUR);
    put_short(CLASS_MAIN, TAG_FEATURE, 2, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_POP, 0, SZ_NONE);
    put_short(CLASS_MAIN, TAG_OUTPUT, 2, SZ_ONE);
    put_short(CLASS_LOCAL, 4'h0, 32'hFFFF_FFFF, SZ_FOUR);
    put_long(2);
    put_long(0);
    put_short(CLASS_MAIN, TAG_END_COLL, 0, SZ_NONE);
    send_desc(1'b0, 1'b1);
    // truncated short item, then truncated long item
    put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 0, SZ_TWO);
    void'(desc_q.pop_back());
    send_desc(1'b0, 1'b0);
    desc_q = '{LONG_PREFIX, 8'h03, 8'h00, 8'hFF};
    send_desc(1'b1, 1'b0);
    // pop on empty stack; later bytes are ignored
    put_short(CLASS_GLOBAL, TAG_POP, 0, SZ_NONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 8, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, 1, SZ_ONE);
    put_short(CLASS_MAIN, TAG_OUTPUT, 0, SZ_ONE);
    send_desc(1'b0, 1'b0);
    // push overflow, then collection overflow
    repeat (NEST_LIMIT + 1) put_short(CLASS_GLOBAL, TAG_PUSH, 0, SZ_NONE);
    send_desc(1'b0, 1'b0);
    repeat (NEST_LIMIT + 1) put_short(CLASS_MAIN, TAG_COLLECTION, 0, SZ_ONE);
    repeat (NEST_LIMIT + 1) put_short(CLASS_MAIN, TAG_END_COLL, 0, SZ_NONE);
    send_desc(1'b0, 1'b0);
    // full stack and full nesting, then unwound: well formed
    repeat (NEST_LIMIT) put_short(CLASS_GLOBAL, TAG_PUSH, 0, SZ_NONE);
    repeat (NEST_LIMIT) put_short(CLASS_GLOBAL, TAG_POP, 0, SZ_NONE);
    repeat (NEST_LIMIT) put_short(CLASS_MAIN, TAG_COLLECTION, 0, SZ_NONE);
    repeat (NEST_LIMIT) put_short(CLASS_MAIN, TAG_END_COLL, 0, SZ_NONE);
    send_desc(1'b0, 1'b0);
    // stray end collection; open collection and open push at the end
    put_short(CLASS_MAIN, TAG_END_COLL, 0, SZ_NONE);
    send_desc(1'b0, 1'b0);
    put_short(CLASS_MAIN, TAG_COLLECTION, 0, SZ_ONE);
    send_desc(1'b1, 1'b0);
    put_short(CLASS_GLOBAL, TAG_PUSH, 0, SZ_NONE);
    send_desc(1'b0, 1'b0);
    // single item over the bit limit; bucket total over the bit limit
    put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 255, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, 129, SZ_ONE);
    put_short(CLASS_MAIN, TAG_FEATURE, 0, SZ_NONE);
    send_desc(1'b0, 1'b0);
    put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 128, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, 200, SZ_ONE);
    put_short(CLASS_MAIN, TAG_OUTPUT, 0, SZ_NONE);
    put_short(CLASS_MAIN, TAG_OUTPUT, 0, SZ_NONE);
    send_desc(1'b0, 1'b0);
    // one report ID too many
    put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 1, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, 1, SZ_ONE);
    for (int i = 0; i <= ID_SLOTS; i++) begin
      put_short(CLASS_GLOBAL, TAG_REPORT_ID, i, SZ_ONE);
      put_short(CLASS_MAIN, TAG_OUTPUT, 0, SZ_NONE);
    end
    send_desc(1'b0, 1'b0);
    // lengths on both sides of the reset maximum
    for (int c = RESET_MAX - 1; c <= RESET_MAX; c++) begin
      put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 8, SZ_ONE);
      put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, c, SZ_ONE);
      put_short(CLASS_MAIN, TAG_OUTPUT, 0, SZ_NONE);
      send_desc(1'b0, 1'b0);
    end
  endtask

  task automatic test_config();
    write_max(1);
    send_desc(1'b1, 1'b0);
    put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 1, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, 1, SZ_ONE);
    put_short(CLASS_MAIN, TAG_FEATURE, 0, SZ_NONE);
    send_desc(1'b0, 1'b0);
    write_max(4097);
    put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 128, SZ_ONE);
    put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, 256, SZ_TWO);
    put_short(CLASS_MAIN, TAG_OUTPUT, 0, SZ_NONE);
    put_short(CLASS_MAIN, TAG_FEATURE, 0, SZ_NONE);
    send_desc(1'b0, 1'b0);
    write_max(RESET_MAX);
  endtask

  // well formed item mix with random content, some broken or noisy
  task automatic build_random();
    int n, opened, pushed;
    logic [7:0] pre;
    opened = 0; pushed = 0;
    n = $urandom_range(1, 14);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0: put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, $urandom_range(1, 16), 2'($urandom_range(1, 3)));
        1: put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, $urandom_range(1, 24), 2'($urandom_range(1, 3)));
        2: put_short(CLASS_GLOBAL, TAG_REPORT_ID, $urandom_range(0, 6), 2'($urandom_range(0, 3)));
        3: begin
          put_short(CLASS_GLOBAL, TAG_PUSH, 0, SZ_NONE);
          pushed++;
        end
        4: begin
          if (pushed > 0) begin
            put_short(CLASS_GLOBAL, TAG_POP, 0, SZ_NONE);
            pushed--;
          end
        end
        5: begin
          put_short(CLASS_MAIN, TAG_COLLECTION, $urandom, 2'($urandom_range(0, 3)));
          opened++;
        end
        6: begin
          if (opened > 0) begin
            put_short(CLASS_MAIN, TAG_END_COLL, 0, SZ_NONE);
            opened--;
          end
        end
        7: put_short(CLASS_MAIN, TAG_OUTPUT, $urandom, 2'($urandom_range(0, 3)));
        8: put_short(CLASS_MAIN, TAG_FEATURE, $urandom, 2'($urandom_range(0, 3)));
        9: begin
          pre = 8'($urandom);
          if (pre == LONG_PREFIX) pre = 8'hFD;
          put_short(pre[3:2], pre[7:4], $urandom, pre[1:0]);
        end
        10: put_long($urandom_range(0, 4));
        default: put_short(CLASS_GLOBAL, 4'($urandom_range(7, 9)), $urandom, SZ_FOUR);
      endcase
    end
    if ($urandom_range(0, 9) != 0) begin
      repeat (opened) put_short(CLASS_MAIN, TAG_END_COLL, 0, SZ_NONE);
      repeat (pushed) put_short(CLASS_GLOBAL, TAG_POP, 0, SZ_NONE);
    end
    // noise: truncate or append raw bytes
    case ($urandom_range(0, 9))
      0: if (desc_q.size() > 0) void'(desc_q.pop_back());
      1: repeat ($urandom_range(1, 6)) desc_q.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  task automatic test_random();
    int descs;
    descs = 0;
    while (bytes_sent < 700 || results_seen < 40) begin
      eager = ($urandom_range(0, 4) == 0);
      build_random();
      send_desc($urandom_range(0, 3) == 0, 1'b1);
      descs++;
      if (descs % 12 == 0) begin
        eager = 1'b0;
        case ($urandom_range(0, 3))
          0: write_max(1);
          1: write_max(4097);
          2: write_max(RESET_MAX);
          default: write_max($urandom_range(1, 4097));
        endcase
      end
    end
    eager = 1'b0;
    write_max(RESET_MAX);
  endtask

  // receiver holds off long while the sender keeps going
  task automatic test_backpressure();
    hold_cycles = 400;
    eager = 1'b1;
    repeat (6) begin
      put_short(CLASS_GLOBAL, TAG_REPORT_SIZE, 8, SZ_ONE);
      put_short(CLASS_GLOBAL, TAG_REPORT_COUNT, $urandom_range(1, 20), SZ_ONE);
      put_short(CLASS_MAIN, TAG_OUTPUT, 0, SZ_NONE);
      send_desc(1'b0, 1'b0);
    end
    eager = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_has_byte = 1'b0;
    in_data_byte = '0;
    in_last = 1'b0;
    mismatches = 0; bytes_sent = 0; results_seen = 0; hold_cycles = 0; eager = 1'b0;
    max_len = RESET_MAX;
    parser_clear();
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed();
    test_config();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
